// File: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define STQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/stq_pkg.sv
// shared types, constants and helpers of the sorted timer queue
package stq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned EXP_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DELAY_W  = 31;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TIME_W   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ADDED     = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_DELETED   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_EXPIRED   = 3'd4,
    STATUS_NONE      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INS,
    OP_DEL,
    OP_POP
  } cell_op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXPIRE
  } back_state_e;

  typedef struct packed {
    kind_e              kind;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    id;
  } item_t;

  typedef struct packed {
    cell_op_e           op;
    logic [TIME_W-1:0]  deadline;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  now;
  } cell_cmd_t;

  typedef struct packed {
    logic            head_due;
    logic            next_due;
    logic            found;
    logic            full;
    logic [ID_W-1:0] head_id;
  } cell_stat_t;

  // a strictly earlier than b, by sign of the wrapping difference
  function automatic logic is_before(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

endpackage

// File: hw/rtl/stq_front.sv
// front end: accepts items, drops unused kinds, queues commands for the back end
module stq_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stq_pkg::KIND_W-1:0]    kind_i,
  input  logic [stq_pkg::DELAY_W-1:0]   delay_ms_i,
  input  logic [stq_pkg::ID_W-1:0]      timer_id_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output stq_pkg::item_t                cmd_o
);

  localparam int unsigned PtrW = (stq_pkg::QUEUE_DEPTH > 1) ? $clog2(stq_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(stq_pkg::QUEUE_DEPTH + 1);

  stq_pkg::item_t  q_mem [stq_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            kind_ok, push, pop;
  stq_pkg::item_t  new_item;

  always_comb begin
    unique case (kind_i)
      stq_pkg::KIND_ADD,
      stq_pkg::KIND_DEL,
      stq_pkg::KIND_TICK: kind_ok = 1'b1;
      default:            kind_ok = 1'b0;
    endcase
  end

  assign new_item.kind  = stq_pkg::kind_e'(kind_i);
  assign new_item.delay = delay_ms_i;
  assign new_item.id    = timer_id_i;

  assign in_ready_o  = (cnt_q != CntW'(stq_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  assign push = in_valid_i && in_ready_o && kind_ok;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(stq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(stq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

endmodule

// File: hw/rtl/stq_cells.sv
// row of sorted timer cells with parallel compare, shift insert and shift remove
module stq_cells #(
  parameter int unsigned Depth = stq_pkg::DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stq_pkg::cell_cmd_t  cmd_i,
  output stq_pkg::cell_stat_t stat_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [stq_pkg::TIME_W-1:0] dl_q   [Depth];
  logic [stq_pkg::ID_W-1:0]   id_q   [Depth];
  logic [stq_pkg::TIME_W-1:0] dl_prev[Depth];
  logic [stq_pkg::TIME_W-1:0] dl_next[Depth];
  logic [stq_pkg::ID_W-1:0]   id_prev[Depth];
  logic [stq_pkg::ID_W-1:0]   id_next[Depth];
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [Depth-1:0]           valid, ins_hit, del_hit, ins_excl, del_excl;

  // neighbor taps
  for (genvar g = 0; g < Depth; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign dl_prev[g] = dl_q[g];
      assign id_prev[g] = id_q[g];
    end else begin : g_mid
      assign dl_prev[g] = dl_q[g-1];
      assign id_prev[g] = id_q[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign dl_next[g] = dl_q[g];
      assign id_next[g] = id_q[g];
    end else begin : g_rest
      assign dl_next[g] = dl_q[g+1];
      assign id_next[g] = id_q[g+1];
    end
  end

  // per-cell compares; free cells always take an insert
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      valid[i]   = (CntW'(i) < cnt_q);
      ins_hit[i] = !valid[i] || stq_pkg::is_before(cmd_i.deadline, dl_q[i]);
      del_hit[i] = valid[i] && (id_q[i] == cmd_i.id);
    end
  end

  // hit somewhere below each cell
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ins_excl[i] = |(ins_hit & ((Depth'(1) << i) - Depth'(1)));
      del_excl[i] = |(del_hit & ((Depth'(1) << i) - Depth'(1)));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      unique case (cmd_i.op)
        stq_pkg::OP_NOP: ;
        stq_pkg::OP_INS: begin
          if (ins_excl[i]) begin
            dl_q[i] <= dl_prev[i];
            id_q[i] <= id_prev[i];
          end else if (ins_hit[i]) begin
            dl_q[i] <= cmd_i.deadline;
            id_q[i] <= cmd_i.id;
          end
        end
        stq_pkg::OP_DEL: begin
          if (del_excl[i] || del_hit[i]) begin
            dl_q[i] <= dl_next[i];
            id_q[i] <= id_next[i];
          end
        end
        stq_pkg::OP_POP: begin
          dl_q[i] <= dl_next[i];
          id_q[i] <= id_next[i];
        end
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      stq_pkg::OP_NOP: ;
      stq_pkg::OP_INS: cnt_d = cnt_q + 1'b1;
      stq_pkg::OP_DEL: if (|del_hit) cnt_d = cnt_q - 1'b1;
      stq_pkg::OP_POP: cnt_d = cnt_q - 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.head_due = (cnt_q != '0) && !stq_pkg::is_before(cmd_i.now, dl_q[0]);
  assign stat_o.found    = |del_hit;
  assign stat_o.full     = (cnt_q == CntW'(Depth));
  assign stat_o.head_id  = id_q[0];

  if (Depth > 1) begin : g_next_due
    assign stat_o.next_due = (cnt_q > CntW'(1)) && !stq_pkg::is_before(cmd_i.now, dl_q[1]);
  end else begin : g_no_next
    assign stat_o.next_due = 1'b0;
  end

endmodule

// File: hw/rtl/stq_back.sv
// back end: time counter, command sequencer and result register
module stq_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  stq_pkg::item_t                 cmd_i,
  output stq_pkg::cell_cmd_t             cell_cmd_o,
  input  stq_pkg::cell_stat_t            cell_stat_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [stq_pkg::STATUS_W-1:0]   status_o,
  output logic [stq_pkg::ID_W-1:0]       expired_id_o,
  output logic                           last_o
);

  stq_pkg::back_state_e            state_q, state_d;
  logic [stq_pkg::TIME_W-1:0]      time_q, time_d;
  logic [stq_pkg::EXP_CNT_W-1:0]   n_q, n_d;
  logic                            out_valid_q;
  logic [stq_pkg::STATUS_W-1:0]    status_q;
  logic [stq_pkg::ID_W-1:0]        exp_id_q;
  logic                            last_q;
  logic                            out_free, emit, exp_last;
  stq_pkg::status_e                res_status;
  logic [stq_pkg::ID_W-1:0]        res_id;
  logic                            res_last;

  assign out_free = !out_valid_q || out_ready_i;
  // the expiry now being emitted ends the list
  assign exp_last = (n_q == stq_pkg::EXP_CNT_W'(stq_pkg::MAX_RESULTS - 1)) ||
                    !cell_stat_i.next_due;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free && cmd_i.kind == stq_pkg::KIND_TICK) begin
          state_d = stq_pkg::BK_EXPIRE;
        end
      end
      stq_pkg::BK_EXPIRE: begin
        if (out_free && (!cell_stat_i.head_due || exp_last)) begin
          state_d = stq_pkg::BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd_ready_o         = 1'b0;
    cell_cmd_o.op       = stq_pkg::OP_NOP;
    cell_cmd_o.deadline = time_q + {1'b0, cmd_i.delay};
    cell_cmd_o.id       = cmd_i.id;
    cell_cmd_o.now      = time_q;
    time_d              = time_q;
    n_d                 = n_q;
    emit                = 1'b0;
    res_status          = stq_pkg::STATUS_ADDED;
    res_id              = '0;
    res_last            = 1'b1;
    unique case (state_q)
      stq_pkg::BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            stq_pkg::KIND_ADD: begin
              emit = 1'b1;
              if (cell_stat_i.full) begin
                res_status = stq_pkg::STATUS_FULL;
              end else begin
                cell_cmd_o.op = stq_pkg::OP_INS;
                res_status    = stq_pkg::STATUS_ADDED;
              end
            end
            stq_pkg::KIND_DEL: begin
              emit          = 1'b1;
              cell_cmd_o.op = stq_pkg::OP_DEL;
              res_status    = cell_stat_i.found ? stq_pkg::STATUS_DELETED
                                                : stq_pkg::STATUS_NOT_FOUND;
            end
            stq_pkg::KIND_TICK: begin
              time_d = time_q + 1'b1;
              n_d    = '0;
            end
            default: ;
          endcase
        end
      end
      stq_pkg::BK_EXPIRE: begin
        if (out_free) begin
          emit = 1'b1;
          if (cell_stat_i.head_due) begin
            cell_cmd_o.op = stq_pkg::OP_POP;
            res_status    = stq_pkg::STATUS_EXPIRED;
            res_id        = cell_stat_i.head_id;
            res_last      = exp_last;
            n_d           = n_q + 1'b1;
          end else begin
            res_status = stq_pkg::STATUS_NONE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::BK_IDLE;
      time_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      time_q  <= time_d;
      n_q     <= n_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= res_status;
      exp_id_q <= res_id;
      last_q   <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign expired_id_o = exp_id_q;
  assign last_o       = last_q;

endmodule

// File: hw/rtl/sorted_timer_queue_unit.sv
// top level of the sorted timer queue
// Sorted timer queue: holds up to DEPTH timers ordered by a 32-bit millisecond
// deadline (wrapping, compared by signed difference). kind 0 adds a timer at
// now + delay_ms behind any equal deadlines, or answers full; kind 1 removes the
// first timer with a matching id; kind 2 advances time by one and lists every
// due head timer (at most 16 per tick, one result each, last set on the final
// one) or answers none; kind 3 is taken and ignored. Items pass a two-entry
// command queue, then a sequencer working on a row of DEPTH compare cells. The
// sequencer answers an add or delete from its idle state with one result; a tick
// moves it to an expiry state that pops one due head per result. The sequencer
// handles one item at a time and each result passes through the single output
// register. The front keeps taking items while the back works or the output
// stalls, until its queue is full.
module sorted_timer_queue_unit #(
  parameter int unsigned DEPTH = stq_pkg::DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [stq_pkg::KIND_W-1:0]    kind_i,
  input  logic [stq_pkg::DELAY_W-1:0]   delay_ms_i,
  input  logic [stq_pkg::ID_W-1:0]      timer_id_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [stq_pkg::STATUS_W-1:0]  status_o,
  output logic [stq_pkg::ID_W-1:0]      expired_id_o,
  output logic                          last_o
);

  // command handoff between front and back
  logic                cmd_valid, cmd_ready;
  stq_pkg::item_t      cmd;
  // sequencer to cell row
  stq_pkg::cell_cmd_t  cell_cmd;
  stq_pkg::cell_stat_t cell_stat;

  // front: accept and classify, buffer up to two commands
  stq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .delay_ms_i  (delay_ms_i),
    .timer_id_i  (timer_id_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // sorted storage: one compare cell per entry, the cells from the insert, delete or pop point onward shifting together
  stq_cells #(
    .Depth (DEPTH)
  ) u_cells (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cell_cmd),
    .stat_o (cell_stat)
  );

  // back: time base, per-command sequencing, registered results
  stq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .cell_cmd_o   (cell_cmd),
    .cell_stat_i  (cell_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

endmodule

// File: hw/rtl/stq_checker.sv
// port-level checks on the sorted timer queue, bound to the top level
`include "assert_macros.svh"

module stq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [stq_pkg::STATUS_W-1:0]  status_i,
  input logic [stq_pkg::ID_W-1:0]      expired_id_i,
  input logic                          last_i
);

  // stalled result holds
  `STQ_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(expired_id_i) && $stable(last_i), "stalled result changed")

  // only an expiry carries an id or continues a list
  `STQ_ASSERT_IMP(a_single_result, out_valid_i && status_i != stq_pkg::STATUS_EXPIRED, expired_id_i == '0 && last_i, "non-expiry result not single or carries id")

  // no status code beyond none expired
  `STQ_ASSERT_IMP(a_status_code, out_valid_i, status_i <= stq_pkg::STATUS_NONE, "undefined status code")

  // the front never stays blocked while the back drains results
  `STQ_ASSERT_NXT(a_front_frees, !in_ready_i && out_valid_i && out_ready_i && last_i, in_ready_i || out_valid_i, "front blocked with back idle")

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_i     (status_o),
  .expired_id_i (expired_id_o),
  .last_i       (last_o)
);

// File: dv/sorted_timer_queue_checker.sv
// result predictor and checker for the sorted timer queue
module sorted_timer_queue_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [stq_pkg::KIND_W-1:0]   kind_i,
  input  logic [stq_pkg::DELAY_W-1:0]  delay_ms_i,
  input  logic [stq_pkg::ID_W-1:0]     timer_id_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [stq_pkg::STATUS_W-1:0] status_i,
  input  logic [stq_pkg::ID_W-1:0]     expired_id_i,
  input  logic                         last_i,
  output int unsigned                  failures_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  checked_o
);

  typedef struct packed {
    stq_pkg::status_e         status;
    logic [stq_pkg::ID_W-1:0] ident;
    logic                     last;
  } result_t;

  // predicted timer list, kept sorted by deadline
  logic [stq_pkg::TIME_W-1:0] due_at   [stq_pkg::DEPTH];
  logic [stq_pkg::ID_W-1:0]   owner_id [stq_pkg::DEPTH];
  int unsigned                pending_timers = 0;
  logic [stq_pkg::TIME_W-1:0] now_ms = '0;

  result_t     awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned compared = 0;

  function automatic bit earlier(input logic [stq_pkg::TIME_W-1:0] a,
                                 input logic [stq_pkg::TIME_W-1:0] b);
    return $signed(a - b) < 0;
  endfunction

  function automatic bit head_due(input int unsigned burst);
    return burst < stq_pkg::MAX_RESULTS && pending_timers != 0 &&
           !earlier(now_ms, due_at[0]);
  endfunction

  function automatic void expect_result(input stq_pkg::status_e s,
                                        input logic [stq_pkg::ID_W-1:0] id,
                                        input logic l);
    result_t r;
    r.status = s;
    r.ident  = id;
    r.last   = l;
    awaited_results.push_back(r);
  endfunction

  function automatic void drop_timer(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < pending_timers; i++) begin
      due_at[i]   = due_at[i+1];
      owner_id[i] = owner_id[i+1];
    end
    pending_timers--;
  endfunction

  function automatic void forecast(input logic [stq_pkg::KIND_W-1:0] kind,
                                   input logic [stq_pkg::DELAY_W-1:0] delay,
                                   input logic [stq_pkg::ID_W-1:0] tid);
    logic [stq_pkg::TIME_W-1:0] deadline;
    logic [stq_pkg::ID_W-1:0]   head_id;
    int                         slot;
    int unsigned                burst;
    case (kind)
      stq_pkg::KIND_ADD: begin
        if (pending_timers == stq_pkg::DEPTH) begin
          expect_result(stq_pkg::STATUS_FULL, '0, 1'b1);
        end else begin
          deadline = now_ms + {1'b0, delay};
          // first entry strictly later than the new deadline, else the tail
          slot = int'(pending_timers);
          for (int i = int'(pending_timers) - 1; i >= 0; i--) begin
            if (earlier(deadline, due_at[i])) slot = i;
          end
          for (int i = int'(pending_timers); i > slot; i--) begin
            due_at[i]   = due_at[i-1];
            owner_id[i] = owner_id[i-1];
          end
          due_at[slot]   = deadline;
          owner_id[slot] = tid;
          pending_timers++;
          expect_result(stq_pkg::STATUS_ADDED, '0, 1'b1);
        end
      end
      stq_pkg::KIND_DEL: begin
        slot = -1;
        for (int i = int'(pending_timers) - 1; i >= 0; i--) begin
          if (owner_id[i] == tid) slot = i;
        end
        if (slot >= 0) begin
          drop_timer(slot);
          expect_result(stq_pkg::STATUS_DELETED, '0, 1'b1);
        end else begin
          expect_result(stq_pkg::STATUS_NOT_FOUND, '0, 1'b1);
        end
      end
      stq_pkg::KIND_TICK: begin
        now_ms = now_ms + 1;
        burst = 0;
        while (head_due(burst)) begin
          head_id = owner_id[0];
          drop_timer(0);
          burst++;
          expect_result(stq_pkg::STATUS_EXPIRED, head_id, !head_due(burst));
        end
        if (burst == 0) expect_result(stq_pkg::STATUS_NONE, '0, 1'b1);
      end
      default: begin
        // unused kind leaves everything as it is
      end
    endcase
  endfunction

  function automatic void check_result(input logic [stq_pkg::STATUS_W-1:0] st,
                                       input logic [stq_pkg::ID_W-1:0] eid,
                                       input logic lst);
    result_t want;
    bit      bad;
    if (awaited_results.size() == 0) begin
      $display("%0t: result with nothing expected: status %0d id %0h last %0b",
               $time, st, eid, lst);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      bad  = 1'b0;
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d got %0d", $time, want.status, st);
        bad = 1'b1;
      end
      if (eid !== want.ident) begin
        $display("%0t: expired_id mismatch, expected %0h got %0h", $time, want.ident, eid);
        bad = 1'b1;
      end
      if (lst !== want.last) begin
        $display("%0t: last mismatch, expected %0b got %0b", $time, want.last, lst);
        bad = 1'b1;
      end
      if (bad) mismatches++;
      compared++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      pending_timers = 0;
      now_ms         = '0;
      outstanding_o <= 0;
    end else begin
      // a result never comes from the item taken at the same edge
      if (out_valid_i && out_ready_i) check_result(status_i, expired_id_i, last_i);
      if (in_valid_i && in_ready_i) forecast(kind_i, delay_ms_i, timer_id_i);
      outstanding_o <= awaited_results.size();
    end
    failures_o <= mismatches;
    checked_o  <= compared;
  end

endmodule

// File: dv/sorted_timer_queue_unit_test.sv
// stimulus, clocking and verdict for the sorted timer queue testbench
module sorted_timer_queue_unit_test;

  localparam int unsigned                ITEM_TARGET  = 260;
  localparam int unsigned                TAIL_FROM    = 225;
  localparam int unsigned                MID_PAUSE_AT = 130;
  localparam int unsigned                LONG_HOLD    = 120;
  localparam int unsigned                DRAIN_CYCLES = 20;
  localparam logic [stq_pkg::KIND_W-1:0] KIND_UNUSED  = 2'd3;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [stq_pkg::KIND_W-1:0]   kind = stq_pkg::KIND_ADD;
  logic [stq_pkg::DELAY_W-1:0]  delay_ms = '0;
  logic [stq_pkg::ID_W-1:0]     timer_id = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [stq_pkg::STATUS_W-1:0] status;
  logic [stq_pkg::ID_W-1:0]     expired_id;
  logic                         last;

  // set for the final stretch of the run, where neither side idles
  logic tail_phase = 1'b0;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned checked;

  // items sent, by kind
  int unsigned adds_sent = 0;
  int unsigned deletes_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned ignored_sent = 0;

  sorted_timer_queue_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .delay_ms_i   (delay_ms),
    .timer_id_i   (timer_id),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .expired_id_o (expired_id),
    .last_o       (last)
  );

  sorted_timer_queue_checker timer_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .delay_ms_i    (delay_ms),
    .timer_id_i    (timer_id),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .expired_id_i  (expired_id),
    .last_i        (last),
    .failures_o    (failures),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #(20 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item and hold it until the block takes it; valid stays high on return
  task automatic send_item(input logic [stq_pkg::KIND_W-1:0] k,
                           input logic [stq_pkg::DELAY_W-1:0] d,
                           input logic [stq_pkg::ID_W-1:0] t);
    in_valid <= 1'b1;
    kind     <= k;
    delay_ms <= d;
    timer_id <= t;
    do @(posedge clk); while (!in_ready);
    case (k)
      stq_pkg::KIND_ADD:  adds_sent++;
      stq_pkg::KIND_DEL:  deletes_sent++;
      stq_pkg::KIND_TICK: ticks_sent++;
      default:            ignored_sent++;
    endcase
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // identifiers mostly from a small pool so deletes hit and duplicates occur
  function automatic logic [stq_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 7) != 0) return stq_pkg::ID_W'($urandom_range(0, 15));
    return stq_pkg::ID_W'($urandom());
  endfunction

  // result side: random stall bursts, steady stretches, and one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned steady_left;
    int unsigned taken;
    bit          long_hold_done;
    hold_left      = 0;
    steady_left    = 0;
    taken          = 0;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!long_hold_done && taken >= 45) begin
        // sender keeps going meanwhile, so the command queue fills and in_ready drops
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end else if (hold_left == 0 && steady_left == 0 && !tail_phase &&
                   $urandom_range(0, 3) == 0) begin
        hold_left   = $urandom_range(1, 7);
        steady_left = $urandom_range(1, 30);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
        if (steady_left != 0) steady_left--;
      end
    end
  end

  initial begin : stimulus
    int unsigned                 roll;
    int unsigned                 volley;
    int unsigned                 sent;
    bit                          mid_pause_done;
    logic [stq_pkg::DELAY_W-1:0] span;
    mid_pause_done = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue answers, far deadline, fill to full, duplicate ids,
    // kind 3, then one tick that expires the whole list
    send_item(stq_pkg::KIND_TICK, '0, '0);
    send_item(stq_pkg::KIND_DEL, '0, 16'h1234);
    send_item(stq_pkg::KIND_ADD, {stq_pkg::DELAY_W{1'b1}}, 16'h0000);
    send_item(stq_pkg::KIND_TICK, {stq_pkg::DELAY_W{1'b1}}, 16'hFFFF);
    send_item(stq_pkg::KIND_DEL, {stq_pkg::DELAY_W{1'b1}}, 16'h0000);
    // equal deadlines must come out in arrival order; id 7 is added twice
    for (int i = 0; i < 15; i++) begin
      send_item(stq_pkg::KIND_ADD, stq_pkg::DELAY_W'(1),
                stq_pkg::ID_W'((i == 8) ? 7 : i));
    end
    // zero delay sorts ahead of the equal-deadline group and fills the list
    send_item(stq_pkg::KIND_ADD, '0, 16'hFFFF);
    send_item(stq_pkg::KIND_ADD, stq_pkg::DELAY_W'(5), 16'hABCD);
    send_item(stq_pkg::KIND_DEL, '0, 16'h0007);
    send_item(KIND_UNUSED, {stq_pkg::DELAY_W{1'b1}}, 16'hFFFF);
    send_item(stq_pkg::KIND_TICK, '0, '0);
    send_item(stq_pkg::KIND_TICK, '0, '0);
    drain_results();

    // random: mostly short deadlines so ticks expire things, plus bursts of adds
    sent = adds_sent + deletes_sent + ticks_sent;
    while (sent < ITEM_TARGET) begin
      if (sent >= TAIL_FROM) tail_phase <= 1'b1;
      if (!mid_pause_done && sent >= MID_PAUSE_AT) begin
        mid_pause_done = 1'b1;
        drain_results();
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        // a run of near-equal deadlines followed by a few ticks
        volley = $urandom_range(1, stq_pkg::DEPTH);
        for (int v = 0; v < volley; v++) begin
          send_item(stq_pkg::KIND_ADD, stq_pkg::DELAY_W'($urandom_range(0, 2)), pick_id());
        end
        repeat ($urandom_range(1, 3)) send_item(stq_pkg::KIND_TICK,
                                                stq_pkg::DELAY_W'($urandom()),
                                                stq_pkg::ID_W'($urandom()));
      end else if (roll < 13) begin
        send_item(KIND_UNUSED, stq_pkg::DELAY_W'($urandom()), stq_pkg::ID_W'($urandom()));
      end else if (roll < 55) begin
        case ($urandom_range(0, 15))
          11, 12:  span = stq_pkg::DELAY_W'($urandom());
          13:      span = {stq_pkg::DELAY_W{1'b1}};
          14:      span = '0;
          15:      span = stq_pkg::DELAY_W'($urandom_range(0, 200));
          default: span = stq_pkg::DELAY_W'($urandom_range(0, 6));
        endcase
        send_item(stq_pkg::KIND_ADD, span, pick_id());
      end else if (roll < 72) begin
        send_item(stq_pkg::KIND_DEL, stq_pkg::DELAY_W'($urandom()), pick_id());
      end else begin
        send_item(stq_pkg::KIND_TICK, stq_pkg::DELAY_W'($urandom()),
                  stq_pkg::ID_W'($urandom()));
      end
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      sent = adds_sent + deletes_sent + ticks_sent;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d adds, %0d deletes, %0d ticks and %0d unused-kind items",
             adds_sent, deletes_sent, ticks_sent, ignored_sent);
    $display("%0d results compared, including full-list drops and multi-timer expiry",
             checked);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_front.sv
hw/rtl/stq_cells.sv
hw/rtl/stq_back.sv
hw/rtl/sorted_timer_queue_unit.sv
hw/rtl/stq_checker.sv
dv/sorted_timer_queue_checker.sv
dv/sorted_timer_queue_unit_test.sv
